### src/dfds_pkg.sv
// Package for the dirty-fragment display scheduler: command and state codes,
// transfer payload structs and the character test.
// No dependencies.
package dfds_pkg;

    localparam int FRAGMENTS_DEF  = 8;
    localparam int FRAGMENT_CHARS = 3;
    localparam int TEXT_W         = 24;
    localparam int FIELD_IDX_W    = 3;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    typedef enum logic [2:0] {
        CMD_LOAD    = 3'd0,
        CMD_PEEK    = 3'd1,
        CMD_ACCEPT  = 3'd2,
        CMD_RESET   = 3'd3,
        CMD_REFRESH = 3'd4
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [2:0]        command;
        logic [2:0]        load_index;
        logic [TEXT_W-1:0] load_text;
        logic              load_last;
    } in_item_t;

    typedef struct packed {
        logic              offer_found;
        logic [2:0]        offer_index;
        logic [TEXT_W-1:0] offer_text;
    } out_item_t;

    // True when any character of the fragment is not a space.
    function automatic logic has_nonspace(input logic [TEXT_W-1:0] text);
        logic hit;
        hit = 1'b0;
        for (int c = 0; c < FRAGMENT_CHARS; c++) begin
            if (text[8*c +: 8] != SPACE_CHAR) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

### src/dirty_fragment_display_scheduler.sv
// Top level of the dirty-fragment display scheduler.
// Depends on dfds_pkg for command codes, payload structs and the space test.

// Every command runs in two steps: in the cycle of the input transfer the
// target and sent text memories are read at the addresses the command needs
// (the loaded fragment, the pending offer, or the next dirty fragment found
// from the scan cursor), and in the execute state the read data comes back
// from the synchronous memories and the block writes back and updates its
// masks. The input is taken again only once that write-back is done, so a new
// command is not taken before the last one is through. A peek gives one result
// transfer; it waits in its execute state only while an earlier result still
// sits unclaimed in the output register. The per-fragment known, forced,
// mismatch and non-space flags, together with one valid bit per memory entry,
// live in flip-flops, so a reset command clears everything at its write-back and
// never needs a sweep through the memories.
module dirty_fragment_display_scheduler #(
    parameter int FRAGMENTS = dfds_pkg::FRAGMENTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dfds_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dfds_pkg::out_item_t m_data
);
    import dfds_pkg::*;

    localparam int IDX_W = (FRAGMENTS > 1) ? $clog2(FRAGMENTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAGMENTS - 1);

    // Text memories, one entry per fragment.
    logic [TEXT_W-1:0] target_mem [FRAGMENTS];
    logic [TEXT_W-1:0] sent_mem   [FRAGMENTS];

    state_t state_reg, state_next;

    // Command captured at the input transfer.
    cmd_t              cmd_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              idx_ok_reg;
    logic [TEXT_W-1:0] text_reg;
    logic              last_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  found_idx_reg;

    // Registered memory read data and the entry valid bits seen with it.
    logic [TEXT_W-1:0] target_rd_reg;
    logic [TEXT_W-1:0] sent_rd_reg;
    logic              target_rd_ok_reg;
    logic              sent_rd_ok_reg;

    // Scheduler state held in flip-flops.
    logic [FRAGMENTS-1:0] target_ent_reg, target_ent_next;
    logic [FRAGMENTS-1:0] sent_ent_reg, sent_ent_next;
    logic [FRAGMENTS-1:0] known_reg, known_next;
    logic [FRAGMENTS-1:0] forced_reg, forced_next;
    logic [FRAGMENTS-1:0] mismatch_reg, mismatch_next;
    logic [FRAGMENTS-1:0] nonspace_reg, nonspace_next;
    logic [IDX_W-1:0]     cursor_reg, cursor_next;
    logic [IDX_W-1:0]     offered_reg, offered_next;
    logic [TEXT_W-1:0]    latched_reg, latched_next;
    logic                 target_valid_reg, target_valid_next;
    logic                 pending_reg, pending_next;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    logic                 in_fire;
    logic                 slot_free;
    logic                 exec_fire;
    logic [FRAGMENTS-1:0] dirty;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [IDX_W-1:0]     target_raddr;
    logic [IDX_W-1:0]     sent_raddr;
    logic                 load_idx_ok;
    logic                 target_we;
    logic                 sent_we;
    logic [TEXT_W-1:0]    target_eff;
    logic [TEXT_W-1:0]    sent_eff;

    assign in_fire   = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    // A peek may only finish when the output register can take its result.
    assign exec_fire = (state_reg == ST_EXEC) && ((cmd_reg != CMD_PEEK) || slot_free);

    // A fragment is dirty when forced, never sent, or sent text differs.
    assign dirty = forced_reg | ~known_reg | mismatch_reg;

    // Round-robin search: the first dirty fragment at or after the cursor.
    // Walking the offsets from the top down lets the smallest offset win.
    always_comb begin
        int j;
        hit     = 1'b0;
        hit_idx = '0;
        for (int n = FRAGMENTS - 1; n >= 0; n--) begin
            j = int'(cursor_reg) + n;
            if (j >= FRAGMENTS) begin
                j = j - FRAGMENTS;
            end
            if (dirty[IDX_W'(j)]) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(j);
            end
        end
    end

    assign load_idx_ok = int'(s_data.load_index) < FRAGMENTS;
    assign sent_raddr  = IDX_W'(s_data.load_index);
    // A peek reads the fragment it is about to offer, an accept the offered one.
    assign target_raddr = (cmd_t'(s_data.command) == CMD_PEEK) ? hit_idx : offered_reg;

    // Entries never written since reset read as zero.
    assign target_eff = target_rd_ok_reg ? target_rd_reg : '0;
    assign sent_eff   = sent_rd_ok_reg ? sent_rd_reg : '0;

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs of the sequencer.
    always_comb begin
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_EXEC: begin
                s_ready = 1'b0;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Write-back in the execute state: read-modify-write of masks and memories.
    always_comb begin
        target_ent_next   = target_ent_reg;
        sent_ent_next     = sent_ent_reg;
        known_next        = known_reg;
        forced_next       = forced_reg;
        mismatch_next     = mismatch_reg;
        nonspace_next     = nonspace_reg;
        cursor_next       = cursor_reg;
        offered_next      = offered_reg;
        latched_next      = latched_reg;
        target_valid_next = target_valid_reg;
        pending_next      = pending_reg;
        target_we         = 1'b0;
        sent_we           = 1'b0;
        m_valid_next      = m_valid_reg && !m_ready;
        m_data_next       = m_data_reg;

        if (exec_fire) begin
            case (cmd_reg)
                CMD_LOAD: begin
                    if (idx_ok_reg) begin
                        target_we                = 1'b1;
                        target_ent_next[idx_reg] = 1'b1;
                        mismatch_next[idx_reg]   = (sent_eff != text_reg);
                        nonspace_next[idx_reg]   = has_nonspace(text_reg);
                    end
                    if (last_reg) begin
                        target_valid_next = 1'b1;
                    end
                end
                CMD_PEEK: begin
                    pending_next             = found_reg;
                    m_valid_next             = 1'b1;
                    m_data_next.offer_found  = found_reg;
                    m_data_next.offer_index  = '0;
                    m_data_next.offer_text   = '0;
                    if (found_reg) begin
                        offered_next            = found_idx_reg;
                        latched_next            = target_eff;
                        m_data_next.offer_index = FIELD_IDX_W'(found_idx_reg);
                        m_data_next.offer_text  = target_eff;
                    end
                end
                CMD_ACCEPT: begin
                    if (pending_reg) begin
                        sent_we                    = 1'b1;
                        sent_ent_next[offered_reg] = 1'b1;
                        known_next[offered_reg]    = 1'b1;
                        forced_next[offered_reg]   = 1'b0;
                        mismatch_next[offered_reg] = (latched_reg != target_eff);
                        cursor_next  = (offered_reg == LAST_IDX) ? '0 : offered_reg + 1'b1;
                        pending_next = 1'b0;
                    end
                end
                CMD_RESET: begin
                    target_ent_next   = '0;
                    sent_ent_next     = '0;
                    known_next        = '0;
                    forced_next       = '0;
                    mismatch_next     = '0;
                    // A cleared fragment holds zero bytes, which are not spaces.
                    nonspace_next     = '1;
                    cursor_next       = '0;
                    offered_next      = '0;
                    latched_next      = '0;
                    target_valid_next = 1'b0;
                    pending_next      = 1'b0;
                end
                CMD_REFRESH: begin
                    if (target_valid_reg && (forced_reg == '0) && (|nonspace_reg)) begin
                        forced_next = '1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Text memories: written at write-back, read in the transfer cycle.
    always_ff @(posedge aclk) begin
        if (target_we) begin
            target_mem[idx_reg] <= text_reg;
        end
        if (sent_we) begin
            sent_mem[offered_reg] <= latched_reg;
        end
        if (in_fire) begin
            target_rd_reg <= target_mem[target_raddr];
            sent_rd_reg   <= sent_mem[sent_raddr];
        end
    end

    // Payload captured at the input transfer, plus the output and offer registers; no reset needed.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cmd_reg          <= cmd_t'(s_data.command);
            idx_reg          <= IDX_W'(s_data.load_index);
            idx_ok_reg       <= load_idx_ok;
            text_reg         <= s_data.load_text;
            last_reg         <= s_data.load_last;
            found_reg        <= target_valid_reg && hit;
            found_idx_reg    <= hit_idx;
            target_rd_ok_reg <= target_ent_reg[target_raddr];
            sent_rd_ok_reg   <= sent_ent_reg[sent_raddr];
        end
        m_data_reg   <= m_data_next;
        latched_reg  <= latched_next;
        offered_reg  <= offered_next;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            target_ent_reg   <= '0;
            sent_ent_reg     <= '0;
            known_reg        <= '0;
            forced_reg       <= '0;
            mismatch_reg     <= '0;
            nonspace_reg     <= '1;
            cursor_reg       <= '0;
            target_valid_reg <= 1'b0;
            pending_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            target_ent_reg   <= target_ent_next;
            sent_ent_reg     <= sent_ent_next;
            known_reg        <= known_next;
            forced_reg       <= forced_next;
            mismatch_reg     <= mismatch_next;
            nonspace_reg     <= nonspace_next;
            cursor_reg       <= cursor_next;
            target_valid_reg <= target_valid_next;
            pending_reg      <= pending_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // An offer can only be pending against a valid target.
    a_pending_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg |-> target_valid_reg)
        else $error("offer pending without a valid target");

    // A result that found nothing carries zero index and zero text.
    a_none_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.offer_found)
            |-> (m_data_reg.offer_index == '0) && (m_data_reg.offer_text == '0))
        else $error("empty offer with non-zero payload");

    // An offered fragment number lies within the screen.
    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.offer_found) |-> (int'(m_data_reg.offer_index) < FRAGMENTS))
        else $error("offered fragment out of range");

    // The input is closed for the cycle after every input transfer.
    a_two_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_ready)
        else $error("input taken during write-back cycle");
`endif

endmodule

### verif/dfds_checker.sv
// Scoreboard for the dirty-fragment display scheduler: it keeps its own copy of
// the screen, the sent text and the masks, and checks every offer that comes out.
// Depends on dfds_pkg for the command codes, the payload structs and the sizes.
module dfds_checker #(
    parameter int FRAGMENTS = dfds_pkg::FRAGMENTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  dfds_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  dfds_pkg::out_item_t m_data,
    output int                  fail_count,
    output int                  offers_waiting,
    output int                  cmds_seen,
    output int                  offers_found,
    output int                  offers_empty
);
    timeunit 1ns;
    timeprecision 1ps;

    import dfds_pkg::*;

    logic [TEXT_W-1:0]    want_text [FRAGMENTS];
    logic [TEXT_W-1:0]    shown_text [FRAGMENTS];
    logic [TEXT_W-1:0]    held_text;
    logic [FRAGMENTS-1:0] known;
    logic [FRAGMENTS-1:0] forced;
    logic [FRAGMENTS-1:0] stale;
    int                   cursor;
    int                   held_slot;
    logic                 screen_ok;
    logic                 offer_open;
    out_item_t            offers_due [$];

    int fails      = 0;
    int cmd_total  = 0;
    int hit_total  = 0;
    int miss_total = 0;

    task automatic clear_screen();
        for (int i = 0; i < FRAGMENTS; i++) begin
            want_text[i]  = '0;
            shown_text[i] = '0;
        end
        held_text  = '0;
        known      = '0;
        forced     = '0;
        stale      = '0;
        cursor     = 0;
        held_slot  = 0;
        screen_ok  = 1'b0;
        offer_open = 1'b0;
    endtask

    // A fragment needs sending when it is forced, was never sent, or has changed.
    function automatic logic [FRAGMENTS-1:0] stale_now();
        logic [FRAGMENTS-1:0] d;
        d = forced;
        for (int i = 0; i < FRAGMENTS; i++) begin
            if (!known[i] || shown_text[i] != want_text[i]) begin
                d[i] = 1'b1;
            end
        end
        return d;
    endfunction

    task automatic predict(input in_item_t it);
        out_item_t offer;
        int        slot;
        logic      blank;
        case (it.command)
            CMD_LOAD: begin
                if (it.load_index < FRAGMENTS) begin
                    want_text[it.load_index] = it.load_text;
                end
                if (it.load_last) begin
                    screen_ok = 1'b1;
                end
                stale = stale_now();
            end
            CMD_PEEK: begin
                offer_open = 1'b0;
                offer      = '0;
                if (screen_ok) begin
                    for (int n = 0; n < FRAGMENTS; n++) begin
                        slot = (cursor + n) % FRAGMENTS;
                        if (stale[slot] && !offer.offer_found) begin
                            held_slot         = slot;
                            held_text         = want_text[slot];
                            offer_open        = 1'b1;
                            offer.offer_found = 1'b1;
                            offer.offer_index = slot[2:0];
                            offer.offer_text  = held_text;
                        end
                    end
                end
                offers_due.push_back(offer);
            end
            CMD_ACCEPT: begin
                if (offer_open) begin
                    shown_text[held_slot] = held_text;
                    known[held_slot]      = 1'b1;
                    forced[held_slot]     = 1'b0;
                    cursor                = (held_slot + 1) % FRAGMENTS;
                    offer_open            = 1'b0;
                    stale                 = stale_now();
                end
            end
            CMD_RESET: begin
                clear_screen();
            end
            CMD_REFRESH: begin
                if (screen_ok && forced == '0) begin
                    blank = 1'b1;
                    for (int i = 0; i < FRAGMENTS; i++) begin
                        for (int c = 0; c < FRAGMENT_CHARS; c++) begin
                            if (want_text[i][8*c +: 8] != SPACE_CHAR) begin
                                blank = 1'b0;
                            end
                        end
                    end
                    if (!blank) begin
                        forced = '1;
                        stale  = stale_now();
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_offer(input out_item_t got);
        out_item_t want;
        if (offers_due.size() == 0) begin
            $display("%0t: offer with none expected, got found=%0d index=%0d text=%06h",
                     $time, got.offer_found, got.offer_index, got.offer_text);
            fails++;
            return;
        end
        want = offers_due.pop_front();
        if (want.offer_found) begin
            hit_total++;
        end else begin
            miss_total++;
        end
        if (got.offer_found !== want.offer_found) begin
            $display("%0t: offer_found expected %0d, got %0d",
                     $time, want.offer_found, got.offer_found);
            fails++;
        end
        if (got.offer_index !== want.offer_index) begin
            $display("%0t: offer_index expected %0d, got %0d",
                     $time, want.offer_index, got.offer_index);
            fails++;
        end
        if (got.offer_text !== want.offer_text) begin
            $display("%0t: offer_text expected %06h, got %06h",
                     $time, want.offer_text, got.offer_text);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_screen();
            offers_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_offer(m_data);
            end
            if (s_valid && s_ready) begin
                cmd_total++;
                predict(s_data);
            end
        end
        fail_count     <= fails;
        offers_waiting <= offers_due.size();
        cmds_seen      <= cmd_total;
        offers_found   <= hit_total;
        offers_empty   <= miss_total;
    end

endmodule

### verif/tb_dirty_fragment_display_scheduler.sv
// Top level of the scheduler testbench: clock, reset, command stimulus and the
// receiver, with dfds_checker beside the block doing prediction and comparison.
// Depends on dfds_pkg, dirty_fragment_display_scheduler and dfds_checker.
module tb_dirty_fragment_display_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import dfds_pkg::*;

    localparam int FRAG      = FRAGMENTS_DEF;
    localparam int ITEM_GOAL = 1850;
    localparam int HOLD_LEN  = 300;

    // Command codes the block does not define; it must ignore them.
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    localparam logic [TEXT_W-1:0] BLANK_TEXT = {FRAGMENT_CHARS{SPACE_CHAR}};

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    int fail_count;
    int offers_waiting;
    int cmds_seen;
    int offers_found;
    int offers_empty;

    // Count of defined commands transferred; ignored codes are left out.
    int sent_items = 0;
    // Each increment asks the receiver for one long hold-off.
    int hold_asks = 0;
    // While set, neither side inserts idle cycles.
    bit quiet = 1'b0;

    // The last text loaded per fragment, so that screens can be resent mostly
    // unchanged and leave most fragments clean.
    logic [TEXT_W-1:0] screen_copy [FRAG];

    dirty_fragment_display_scheduler #(
        .FRAGMENTS (FRAG)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    dfds_checker #(
        .FRAGMENTS (FRAG)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .fail_count     (fail_count),
        .offers_waiting (offers_waiting),
        .cmds_seen      (cmds_seen),
        .offers_found   (offers_found),
        .offers_empty   (offers_empty)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // The overall limit allows for every peek waiting out the receiver, the long
    // hold-off and the sender's gaps, several times over.
    initial begin
        #2_000_000;
        $display("%0t: timed out with %0d offers still expected", $time, offers_waiting);
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver. It drops ready at random, seven times in a hundred, never while the
    // quiet stretch runs, and on request holds it low for a long stretch that it
    // counts itself. At most one assignment to m_ready happens per clock edge.
    initial begin
        int hold_done;
        hold_done = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_done != hold_asks) begin
                hold_done++;
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= 7);
            end
        end
    end

    // Offers one command and returns at the edge where it is transferred. Here valid is
    // only lowered when an idle gap is inserted, so back-to-back commands keep it
    // high and it is never lowered and raised within the same step.
    task automatic issue(input logic [2:0] cmd, input logic [2:0] idx,
                         input logic [TEXT_W-1:0] text, input logic last);
        in_item_t it;
        it.command    = cmd;
        it.load_index = idx;
        it.load_text  = text;
        it.load_last  = last;
        if (!quiet && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (cmd <= CMD_REFRESH) begin
            sent_items++;
        end
    endtask

    // Fragment text with a bias towards spaces and the extremes, since the refresh
    // command behaves differently on an all-space screen.
    function automatic logic [TEXT_W-1:0] pick_text();
        logic [TEXT_W-1:0] t;
        t = TEXT_W'($urandom());
        case ($urandom_range(9))
            0: t = BLANK_TEXT;
            1: t[8*$urandom_range(FRAGMENT_CHARS-1) +: 8] = SPACE_CHAR;
            2: t = '1;
            3: t = '0;
            default: begin
            end
        endcase
        return t;
    endfunction

    // Sends a whole screen, one load per fragment starting at a random fragment,
    // with the final load marked as the last. Style 0 gives fresh text, style 1
    // resends the previous screen with a few changes, style 2 is all spaces.
    // Now and then a peek is slipped in while the screen is half loaded.
    task automatic load_screen(input int style);
        int                start;
        int                idx;
        logic [TEXT_W-1:0] text;
        start = $urandom_range(FRAG - 1);
        for (int k = 0; k < FRAG; k++) begin
            idx = (start + k) % FRAG;
            if (style == 2) begin
                text = BLANK_TEXT;
            end else if (style == 1 && $urandom_range(7) != 0) begin
                text = screen_copy[idx];
            end else begin
                text = pick_text();
            end
            screen_copy[idx] = text;
            issue(CMD_LOAD, idx[2:0], text, k == FRAG - 1);
            if (k == FRAG / 2 && $urandom_range(9) == 0) begin
                issue(CMD_PEEK, 3'($urandom_range(7)), TEXT_W'($urandom()),
                      1'($urandom_range(1)));
            end
        end
    endtask

    // The normal consumer loop: peek, usually accept what was offered, now and then
    // refresh. The fields the command does not use carry random values throughout.
    task automatic drain(input int rounds);
        repeat (rounds) begin
            issue(CMD_PEEK, 3'($urandom_range(7)), TEXT_W'($urandom()),
                  1'($urandom_range(1)));
            if ($urandom_range(9) != 0) begin
                issue(CMD_ACCEPT, 3'($urandom_range(7)), TEXT_W'($urandom()),
                      1'($urandom_range(1)));
            end
            if ($urandom_range(29) == 0) begin
                issue(CMD_REFRESH, 3'($urandom_range(7)), TEXT_W'($urandom()),
                      1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        int   pick;
        int   idx;
        logic paused;
        paused  = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        for (int i = 0; i < FRAG; i++) begin
            screen_copy[i] = '0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening. Before any screen is complete a peek finds nothing,
        // an accept has no offer to take and a refresh is ignored.
        issue(CMD_PEEK, 3'd0, '0, 1'b0);
        issue(CMD_ACCEPT, 3'd0, '0, 1'b0);
        issue(CMD_REFRESH, 3'd0, '0, 1'b0);
        // Undefined codes are dropped without a result.
        issue(CMD_SPARE_A, 3'd7, '1, 1'b1);
        issue(CMD_SPARE_B, 3'd0, '0, 1'b0);
        issue(CMD_SPARE_C, 3'd7, '1, 1'b1);
        // A partial screen with the extreme texts is still not valid to peek.
        issue(CMD_LOAD, 3'd0, '1, 1'b0);
        issue(CMD_LOAD, 3'd7, '0, 1'b0);
        issue(CMD_PEEK, 3'd0, '0, 1'b0);
        // Marking the last load makes the partly loaded screen valid; every
        // fragment is unsent, so the scan walks up from fragment zero.
        issue(CMD_LOAD, 3'd3, BLANK_TEXT, 1'b1);
        issue(CMD_PEEK, 3'd0, '0, 1'b0);
        issue(CMD_ACCEPT, 3'd0, '0, 1'b0);
        issue(CMD_PEEK, 3'd0, '0, 1'b0);
        issue(CMD_ACCEPT, 3'd0, '0, 1'b0);
        // Refresh forces every fragment; a second refresh while forced is ignored.
        issue(CMD_REFRESH, 3'd0, '0, 1'b0);
        issue(CMD_REFRESH, 3'd0, '0, 1'b0);
        issue(CMD_PEEK, 3'd0, '0, 1'b0);
        issue(CMD_ACCEPT, 3'd0, '0, 1'b0);
        issue(CMD_PEEK, 3'd0, '0, 1'b0);
        // The reset command clears everything, so the next peek finds nothing.
        issue(CMD_RESET, 3'd0, '0, 1'b0);
        issue(CMD_PEEK, 3'd0, '0, 1'b0);

        // Random part, mostly whole screens followed by peek and accept rounds,
        // with partial updates, refreshes, bursts, resets and noise mixed in.
        while (sent_items < ITEM_GOAL) begin
            quiet = (sent_items >= 800 && sent_items < 1000);

            // Long receiver hold-off while the sender keeps offering peeks, so
            // that the output register fills and the input is stalled.
            if (hold_asks == 0 && sent_items >= 600) begin
                hold_asks++;
                repeat (16) begin
                    issue(CMD_PEEK, 3'($urandom_range(7)), TEXT_W'($urandom()),
                          1'($urandom_range(1)));
                end
            end

            // Sender pause until every outstanding offer has been collected.
            if (!paused && sent_items >= 1200) begin
                paused = 1'b1;
                s_valid <= 1'b0;
                do @(posedge aclk); while (offers_waiting != 0);
            end

            pick = $urandom_range(99);
            if (pick < 45) begin
                load_screen(($urandom_range(9) == 0) ? 2 : $urandom_range(1));
                drain($urandom_range(10, 3));
            end else if (pick < 65) begin
                repeat ($urandom_range(3, 1)) begin
                    idx              = $urandom_range(FRAG - 1);
                    screen_copy[idx] = pick_text();
                    issue(CMD_LOAD, idx[2:0], screen_copy[idx], $urandom_range(3) == 0);
                end
                drain($urandom_range(6, 3));
            end else if (pick < 75) begin
                issue(CMD_REFRESH, 3'($urandom_range(7)), TEXT_W'($urandom()),
                      1'($urandom_range(1)));
                drain($urandom_range(FRAG + 1, 4));
            end else if (pick < 85) begin
                repeat ($urandom_range(4, 1)) begin
                    issue(3'($urandom_range(7)), 3'($urandom_range(7)),
                          TEXT_W'($urandom()), 1'($urandom_range(1)));
                end
            end else if (pick < 90) begin
                issue(CMD_RESET, 3'($urandom_range(7)), TEXT_W'($urandom()),
                      1'($urandom_range(1)));
                load_screen(0);
            end else begin
                repeat ($urandom_range(5, 2)) begin
                    issue(CMD_PEEK, 3'($urandom_range(7)), TEXT_W'($urandom()),
                          1'($urandom_range(1)));
                end
                issue(CMD_ACCEPT, 3'($urandom_range(7)), TEXT_W'($urandom()),
                      1'($urandom_range(1)));
            end
        end
        quiet = 1'b0;

        // All stimulus is in; wait for the last offers, then a little longer to
        // catch any stray transfer from the block.
        s_valid <= 1'b0;
        do @(posedge aclk); while (offers_waiting != 0);
        repeat (10) @(posedge aclk);

        $display("Run covered %0d command transfers: %0d peeks offered a fragment,",
                 cmds_seen, offers_found);
        $display("%0d found none, including a long receiver hold-off, a drain pause %s",
                 offers_empty, "and a stretch without idling.");
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
